[rtl/gasp_pkg.sv]
package gasp_pkg;

  localparam int unsigned MAX_GLYPHS_DEF = 256;

  localparam int unsigned KEY_W = 32;
  localparam int unsigned DIM_W = 12;
  localparam int unsigned POS_W = 13;
  localparam int unsigned ID_W  = 9;
  localparam int unsigned ST_W  = 3;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [POS_W-1:0] ATLAS_MAX_RST = 13'd2048;
  localparam logic [POS_W-1:0] POW2_CAP      = 13'd4096;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_WIDTH  = 1'b0,
    REG_MAX_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef enum logic [ST_W-1:0] {
    ST_PLACED = 3'd0,
    ST_FOUND  = 3'd1,
    ST_NONE   = 3'd2,
    ST_WIDE   = 3'd3,
    ST_HEIGHT = 3'd4,
    ST_FULL   = 3'd5
  } status_t;

  // atlas limits as seen by the packer
  typedef struct packed {
    logic [POS_W-1:0] max_w;
    logic [POS_W-1:0] max_h;
  } limits_t;

  // one stored glyph: key and its padded-inside position
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [POS_W-1:0] pos_y;
    logic [POS_W-1:0] pos_x;
  } entry_t;

  // smallest power of two not below v, capped at 4096
  function automatic logic [POS_W-1:0] pow2_up(input logic [POS_W-1:0] v);
    logic [POS_W-1:0] p;
    p = POW2_CAP;
    for (int i = POS_W - 1; i >= 0; i--) begin
      if (v <= POS_W'(1 << i)) begin
        p = POS_W'(1 << i);
      end
    end
    return p;
  endfunction

endpackage

[rtl/gasp_store.sv]
module gasp_store #(
  parameter int unsigned DEPTH = gasp_pkg::MAX_GLYPHS_DEF
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  gasp_pkg::entry_t           wr_data,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr,
  output gasp_pkg::entry_t           rd_data
);
  import gasp_pkg::*;

  entry_t mem [DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/gasp_ctrl.sv]
module gasp_ctrl #(
  parameter int unsigned MAX_GLYPHS = gasp_pkg::MAX_GLYPHS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  gasp_pkg::limits_t             limits,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_has_bitmap,
  input  logic [gasp_pkg::KEY_W-1:0]    in_bitmap_key,
  input  logic [gasp_pkg::DIM_W-1:0]    in_bitmap_width,
  input  logic [gasp_pkg::DIM_W-1:0]    in_bitmap_height,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [gasp_pkg::ID_W-1:0]     out_glyph_id,
  output logic [gasp_pkg::POS_W-1:0]    out_pos_x,
  output logic [gasp_pkg::POS_W-1:0]    out_pos_y,
  output logic [gasp_pkg::ST_W-1:0]     out_status,
  output logic [gasp_pkg::POS_W-1:0]    out_atlas_width_pow2,
  output logic [gasp_pkg::POS_W-1:0]    out_atlas_height_pow2,
  output logic                          mem_wr_en,
  output logic [$clog2(MAX_GLYPHS)-1:0] mem_wr_addr,
  output gasp_pkg::entry_t              mem_wr_data,
  output logic [$clog2(MAX_GLYPHS)-1:0] mem_rd_addr,
  input  gasp_pkg::entry_t              mem_rd_data
);
  import gasp_pkg::*;

  localparam int unsigned IdxW = $clog2(MAX_GLYPHS);
  localparam int unsigned CntW = $clog2(MAX_GLYPHS + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(MAX_GLYPHS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_CHECK,
    S_FIT,
    S_RESP
  } state_t;

  state_t              state_r;
  logic [IdxW-1:0]     idx_r;
  logic [CntW-1:0]     cnt_r;
  logic [POS_W-1:0]    cursor_r;
  logic [POS_W-1:0]    shelf_r;
  logic [POS_W-1:0]    used_w_r;
  logic [POS_W-1:0]    used_h_r;
  logic [KEY_W-1:0]    key_r;
  logic [DIM_W-1:0]    w_r;
  logic [DIM_W-1:0]    h_r;
  logic [CntW-1:0]     id_r;
  logic [POS_W-1:0]    px_r;
  logic [POS_W-1:0]    py_r;
  status_t             st_r;

  logic                out_valid_r;
  logic [ID_W-1:0]     out_id_r;
  logic [POS_W-1:0]    out_px_r;
  logic [POS_W-1:0]    out_py_r;
  logic [ST_W-1:0]     out_st_r;
  logic [POS_W-1:0]    out_wp2_r;
  logic [POS_W-1:0]    out_hp2_r;

  logic                in_xfer;
  logic                out_free;
  logic                last_entry;
  logic                key_hit;
  logic [POS_W:0]      pad_w;
  logic [POS_W:0]      row_end;
  logic [POS_W:0]      pad_bottom;
  logic [POS_W-1:0]    right;
  logic                place_ok;

  assign in_xfer    = in_valid && !in_stall;
  assign in_stall   = (state_r != S_IDLE);
  assign out_free   = !out_valid_r || !out_stall;
  assign last_entry = (CntW'(idx_r) == cnt_r - CntW'(1));
  assign key_hit    = (mem_rd_data.key == key_r);

  assign pad_w      = (POS_W+1)'(w_r) + (POS_W+1)'(2);
  assign row_end    = (POS_W+1)'(cursor_r) + pad_w;
  assign pad_bottom = (POS_W+1)'(shelf_r) + (POS_W+1)'(h_r) + (POS_W+1)'(2);
  assign right      = row_end[POS_W-1:0];
  assign place_ok   = (pad_bottom <= (POS_W+1)'(limits.max_h));

  assign mem_rd_addr       = (state_r == S_SEARCH) ? idx_r + IdxW'(1) : IdxW'(1);
  assign mem_wr_en         = (state_r == S_FIT) && place_ok;
  assign mem_wr_addr       = cnt_r[IdxW-1:0];
  assign mem_wr_data.key   = key_r;
  assign mem_wr_data.pos_x = cursor_r + POS_W'(1);
  assign mem_wr_data.pos_y = shelf_r + POS_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= CntW'(1);
      cursor_r    <= '0;
      shelf_r     <= '0;
      used_w_r    <= '0;
      used_h_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // S_RESP reloads the output register itself
      if (out_valid_r && !out_stall && (state_r != S_RESP)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            key_r <= in_bitmap_key;
            w_r   <= in_bitmap_width;
            h_r   <= in_bitmap_height;
            id_r  <= '0;
            px_r  <= '0;
            py_r  <= '0;
            idx_r <= IdxW'(1);
            if (!in_has_bitmap) begin
              st_r    <= ST_NONE;
              state_r <= S_RESP;
            end else if (cnt_r == CntW'(1)) begin
              state_r <= S_CHECK;
            end else begin
              state_r <= S_SEARCH;
            end
          end
        end
        S_SEARCH: begin
          // read data here belongs to entry idx_r
          if (key_hit) begin
            id_r    <= CntW'(idx_r);
            px_r    <= mem_rd_data.pos_x;
            py_r    <= mem_rd_data.pos_y;
            st_r    <= ST_FOUND;
            state_r <= S_RESP;
          end else if (last_entry) begin
            state_r <= S_CHECK;
          end else begin
            idx_r <= idx_r + IdxW'(1);
          end
        end
        S_CHECK: begin
          if (cnt_r == CntFull) begin
            st_r    <= ST_FULL;
            state_r <= S_RESP;
          end else if (pad_w > (POS_W+1)'(limits.max_w)) begin
            st_r    <= ST_WIDE;
            state_r <= S_RESP;
          end else begin
            // row wrap sticks even if the height check fails
            if (row_end > (POS_W+1)'(limits.max_w)) begin
              cursor_r <= '0;
              shelf_r  <= used_h_r;
            end
            state_r <= S_FIT;
          end
        end
        S_FIT: begin
          if (!place_ok) begin
            st_r <= ST_HEIGHT;
          end else begin
            if (right > used_w_r) begin
              used_w_r <= right;
            end
            if (pad_bottom[POS_W-1:0] > used_h_r) begin
              used_h_r <= pad_bottom[POS_W-1:0];
            end
            id_r     <= cnt_r;
            px_r     <= mem_wr_data.pos_x;
            py_r     <= mem_wr_data.pos_y;
            st_r     <= ST_PLACED;
            cnt_r    <= cnt_r + CntW'(1);
            cursor_r <= right;
          end
          state_r <= S_RESP;
        end
        S_RESP: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_id_r    <= ID_W'(id_r);
            out_px_r    <= px_r;
            out_py_r    <= py_r;
            out_st_r    <= st_r;
            out_wp2_r   <= pow2_up(used_w_r);
            out_hp2_r   <= pow2_up(used_h_r);
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid             = out_valid_r;
  assign out_glyph_id          = out_id_r;
  assign out_pos_x             = out_px_r;
  assign out_pos_y             = out_py_r;
  assign out_status            = out_st_r;
  assign out_atlas_width_pow2  = out_wp2_r;
  assign out_atlas_height_pow2 = out_hp2_r;

  a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_wr_en |-> (cnt_r < CntFull) && (cnt_r != CntW'(0)))
    else $error("store write at id outside table");

  a_search_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEARCH) |-> (CntW'(idx_r) < cnt_r) && (idx_r != IdxW'(0)))
    else $error("search index outside written entries");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && (cnt_r != $past(cnt_r)) |-> (cnt_r == $past(cnt_r) + CntW'(1)))
    else $error("glyph count moved by other than one");

  a_found_id: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP) && (st_r == ST_FOUND) |-> (id_r != '0) && (id_r < cnt_r))
    else $error("found id not a placed glyph");

endmodule

[rtl/glyph_atlas_shelf_packer_unit.sv]
// Channel | Handshake           | Payload
// in      | in_valid / in_stall | has_bitmap, bitmap_key, bitmap_width, bitmap_height
// out     | out_valid/out_stall | glyph_id, pos_x, pos_y, status, atlas_*_pow2
// cfg     | cfg_valid/cfg_ready | cfg_index, cfg_wdata (0 max width, 1 max height)
//
// A bitmap request first searches the N glyphs stored (up to MAX_GLYPHS-1) for its key,
// reading the glyph memory one entry per cycle; if the key is not found, it then checks
// the fit and places the glyph. A null request goes straight to the result load.
// One request is in work at a time; the output register holds a finished result so
// the next request can be taken while it waits.
// Reset (rst_n low, synchronous) clears placement state; the glyph memory is not cleared.
module glyph_atlas_shelf_packer_unit #(
  parameter int unsigned MAX_GLYPHS = gasp_pkg::MAX_GLYPHS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_has_bitmap,
  input  logic [gasp_pkg::KEY_W-1:0]         in_bitmap_key,
  input  logic [gasp_pkg::DIM_W-1:0]         in_bitmap_width,
  input  logic [gasp_pkg::DIM_W-1:0]         in_bitmap_height,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [gasp_pkg::ID_W-1:0]          out_glyph_id,
  output logic [gasp_pkg::POS_W-1:0]         out_pos_x,
  output logic [gasp_pkg::POS_W-1:0]         out_pos_y,
  output logic [gasp_pkg::ST_W-1:0]          out_status,
  output logic [gasp_pkg::POS_W-1:0]         out_atlas_width_pow2,
  output logic [gasp_pkg::POS_W-1:0]         out_atlas_height_pow2,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [gasp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gasp_pkg::POS_W-1:0]         cfg_wdata
);
  import gasp_pkg::*;

  localparam int unsigned IdxW = $clog2(MAX_GLYPHS);

  limits_t          limits_r;
  logic             mem_wr_en;
  logic [IdxW-1:0]  mem_wr_addr;
  entry_t           mem_wr_data;
  logic [IdxW-1:0]  mem_rd_addr;
  entry_t           mem_rd_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limits_r.max_w <= ATLAS_MAX_RST;
      limits_r.max_h <= ATLAS_MAX_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_MAX_WIDTH:  limits_r.max_w <= cfg_wdata;
        REG_MAX_HEIGHT: limits_r.max_h <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  gasp_ctrl #(
    .MAX_GLYPHS(MAX_GLYPHS)
  ) u_ctrl (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .limits                (limits_r),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_has_bitmap         (in_has_bitmap),
    .in_bitmap_key         (in_bitmap_key),
    .in_bitmap_width       (in_bitmap_width),
    .in_bitmap_height      (in_bitmap_height),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_glyph_id          (out_glyph_id),
    .out_pos_x             (out_pos_x),
    .out_pos_y             (out_pos_y),
    .out_status            (out_status),
    .out_atlas_width_pow2  (out_atlas_width_pow2),
    .out_atlas_height_pow2 (out_atlas_height_pow2),
    .mem_wr_en             (mem_wr_en),
    .mem_wr_addr           (mem_wr_addr),
    .mem_wr_data           (mem_wr_data),
    .mem_rd_addr           (mem_rd_addr),
    .mem_rd_data           (mem_rd_data)
  );

  gasp_store #(
    .DEPTH(MAX_GLYPHS)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

endmodule
